[hw/rtl/dpd_pkg.sv]
package dpd_pkg;

  // default fixed-point format and CORDIC depth
  localparam int FRAC_BITS_DEF = 20;
  localparam int TRIG_ITER_DEF = 24;

  // gravity after reset: 9.806 in Q.20
  localparam logic [30:0] GRAVITY_RESET = 31'd10282336;

  // trig constants, Q6.30
  localparam logic signed [35:0] TRIG_ONE    = 36'sd1073741824;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;

  // arctangent of 2^-i in Q30: truncated for the first ten steps, 2^(30-i) after
  function automatic logic signed [35:0] atan_q30(input int i);
    logic signed [35:0] v;
    case (i)
      0:       v = 36'sd843314856;
      1:       v = 36'sd497837829;
      2:       v = 36'sd263043836;
      3:       v = 36'sd133525158;
      4:       v = 36'sd67021686;
      5:       v = 36'sd33543515;
      6:       v = 36'sd16775850;
      7:       v = 36'sd8388437;
      8:       v = 36'sd4194282;
      9:       v = 36'sd2097149;
      default: v = 36'sd1 <<< (30 - i);
    endcase
    return v;
  endfunction

  // register count of one sin/cos unit
  function automatic int trig_latency(input int fb, input int it);
    return 35 - fb + it;
  endfunction

endpackage

[hw/rtl/dpd_sincos.sv]
module dpd_sincos #(
  parameter int FRAC_BITS       = dpd_pkg::FRAC_BITS_DEF,
  parameter int TRIG_ITERATIONS = dpd_pkg::TRIG_ITER_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] angle,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);

  localparam int WM = 63 - FRAC_BITS;   // magnitude of angle in Q30
  localparam int NQ = 30 - FRAC_BITS;   // quotient bits of the 2*pi reduction
  localparam int NI = TRIG_ITERATIONS;

  logic [WM-1:0]      mag_r [NQ+1];
  logic               neg_r [NQ+1];
  logic [32:0]        amag;
  logic signed [35:0] rs_r;
  logic signed [35:0] wr_r;
  logic signed [35:0] cx_r [NI+1];
  logic signed [35:0] cy_r [NI+1];
  logic signed [35:0] cz_r [NI+1];
  logic               cf_r [NI+1];
  logic signed [35:0] xc;
  logic signed [35:0] yc;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;

  // magnitude and sign, widened to Q30
  assign amag = angle[32] ? 33'(-angle) : 33'(angle);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[0] <= WM'(amag) << (30 - FRAC_BITS);
      neg_r[0] <= angle[32];
    end
  end

  // restoring reduction modulo 2*pi, one quotient bit per stage
  for (genvar s = 1; s <= NQ; s++) begin : g_red
    localparam logic [WM-1:0] STEP = WM'(dpd_pkg::TWO_PI_Q30) << (NQ - s);
    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[s] <= (mag_r[s-1] >= STEP) ? mag_r[s-1] - STEP : mag_r[s-1];
        neg_r[s] <= neg_r[s-1];
      end
    end
  end

  // sign back on, wrap into [-pi, pi], fold into [-pi/2, pi/2]
  always_ff @(posedge clk) begin
    if (en) begin
      rs_r <= neg_r[NQ] ? -$signed({3'b000, mag_r[NQ][32:0]})
                        :  $signed({3'b000, mag_r[NQ][32:0]});
      if (rs_r > dpd_pkg::PI_Q30) begin
        wr_r <= rs_r - dpd_pkg::TWO_PI_Q30;
      end else if (rs_r < -dpd_pkg::PI_Q30) begin
        wr_r <= rs_r + dpd_pkg::TWO_PI_Q30;
      end else begin
        wr_r <= rs_r;
      end
      cx_r[0] <= dpd_pkg::CORDIC_GAIN;
      cy_r[0] <= '0;
      if (wr_r > dpd_pkg::HALF_PI_Q30) begin
        cz_r[0] <= wr_r - dpd_pkg::PI_Q30;
        cf_r[0] <= 1'b1;
      end else if (wr_r < -dpd_pkg::HALF_PI_Q30) begin
        cz_r[0] <= wr_r + dpd_pkg::PI_Q30;
        cf_r[0] <= 1'b1;
      end else begin
        cz_r[0] <= wr_r;
        cf_r[0] <= 1'b0;
      end
    end
  end

  // rotation-mode CORDIC, one iteration per stage
  for (genvar i = 0; i < NI; i++) begin : g_cor
    localparam logic signed [35:0] ANG = dpd_pkg::atan_q30(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz_r[i] >= 0) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - ANG;
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + ANG;
        end
        cf_r[i+1] <= cf_r[i];
      end
    end
  end

  // clamp overshoot to [-1, 1], undo the fold
  always_comb begin
    if (cx_r[NI] > dpd_pkg::TRIG_ONE) begin
      xc = dpd_pkg::TRIG_ONE;
    end else if (cx_r[NI] < -dpd_pkg::TRIG_ONE) begin
      xc = -dpd_pkg::TRIG_ONE;
    end else begin
      xc = cx_r[NI];
    end
    if (cy_r[NI] > dpd_pkg::TRIG_ONE) begin
      yc = dpd_pkg::TRIG_ONE;
    end else if (cy_r[NI] < -dpd_pkg::TRIG_ONE) begin
      yc = -dpd_pkg::TRIG_ONE;
    end else begin
      yc = cy_r[NI];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= 32'(cf_r[NI] ? -xc : xc);
      sin_r <= 32'(cf_r[NI] ? -yc : yc);
    end
  end

  assign cos_q30 = cos_r;
  assign sin_q30 = sin_r;

endmodule

[hw/rtl/dpd_div.sv]
module dpd_div #(
  parameter int WN = 64,
  parameter int WD = 32,
  parameter int WQ = 34
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [WN-1:0] dividend,
  input  logic [WD-1:0]      divisor,
  output logic signed [WQ:0] quotient
);

  // compare width: covers the remainder and the largest shifted divisor
  localparam int WC = ((WN > WD + WQ) ? WN : WD + WQ) + 1;

  logic [WN-1:0]       rem_r [WQ+1];
  logic [WD-1:0]       d_r   [WQ+1];
  logic                neg_r [WQ+1];
  logic [WQ-1:0]       q_r   [WQ+1];
  logic signed [WQ:0]  quo_r;

  // magnitude and sign in; quotient truncates toward zero
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= dividend[WN-1] ? WN'(-dividend) : WN'(dividend);
      d_r[0]   <= divisor;
      neg_r[0] <= dividend[WN-1];
      q_r[0]   <= '0;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar s = 1; s <= WQ; s++) begin : g_stage
    logic [WC-1:0] trial;
    assign trial = WC'(rem_r[s-1]) - (WC'(d_r[s-1]) << (WQ - s));
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= trial[WC-1] ? rem_r[s-1] : trial[WN-1:0];
        q_r[s]   <= {q_r[s-1][WQ-2:0], ~trial[WC-1]};
        d_r[s]   <= d_r[s-1];
        neg_r[s] <= neg_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= neg_r[WQ] ? -$signed({1'b0, q_r[WQ]}) : $signed({1'b0, q_r[WQ]});
    end
  end

  assign quotient = quo_r;

endmodule

[hw/rtl/double_pendulum_derivative_eval.sv]
// Channel | Dir | Fields (low bits first)
// in_     | in  | tdata: angle_upper, angle_lower, momentum_upper, momentum_lower
// out_    | out | tdata: rate_angle_upper, rate_angle_lower, rate_momentum_upper,
//         |     |        rate_momentum_lower; tuser: overflow
// cfg_    | in  | wr_data: gravity (Q.FRAC_BITS), written when wr_en is high
//
// One transaction enters per cycle unless the output stalls; the pipeline length is
// set by the CORDIC stages and the one-bit-per-stage divider for the coupling term.
// rst_n (synchronous) clears the valid bits and loads gravity with its default.
// A stall on the output freezes every stage together; nothing is dropped or doubled.
module double_pendulum_derivative_eval #(
  parameter int FRAC_BITS       = dpd_pkg::FRAC_BITS_DEF,
  parameter int TRIG_ITERATIONS = dpd_pkg::TRIG_ITER_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // angle_upper, angle_lower, momentum_upper, momentum_lower
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // rate_angle_upper, rate_angle_lower,
                                    // rate_momentum_upper, rate_momentum_lower
  output logic [0:0]    out_tuser,  // overflow
  input  logic          cfg_wr_en,
  input  logic [30:0]   cfg_wr_data
);

  localparam int LT   = dpd_pkg::trig_latency(FRAC_BITS, TRIG_ITERATIONS);
  localparam int WPP  = 64 - FRAC_BITS;   // p*p in Q.F
  localparam int WS   = 65 - FRAC_BITS;   // pp + 2*qq, and the two coupling terms
  localparam int WI   = 66 - FRAC_BITS;   // inner
  localparam int WNU  = 67 - FRAC_BITS;   // numerator of f2
  localparam int WQD  = 34;
  localparam int LDQ  = WQD + 2;
  localparam int WQF  = WNU - 1;
  localparam int LF   = WQF + 2;
  localparam int WSAT = WNU + 1;
  localparam int LAT  = LT + 8 + LF;
  localparam int DDQ  = 5 + LF - LDQ;
  localparam int DG   = 6 + LF;

  localparam logic signed [WSAT-1:0] SMAX = WSAT'(32'sh7FFF_FFFF);
  localparam logic signed [WSAT-1:0] SMIN = WSAT'(32'sh8000_0000);

  logic              en;
  logic [LAT-1:0]    vld_r;
  logic [LAT-1:0]    vld_nxt;
  logic [30:0]       gravity_r;

  // global advance: every stage moves unless the output holds a waiting transaction
  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;
  assign vld_nxt   = {vld_r[LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // gravity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= dpd_pkg::GRAVITY_RESET;
    end else if (cfg_wr_en) begin
      gravity_r <= cfg_wr_data;
    end
  end

  // trig units: difference angle, upper angle, lower angle
  logic signed [32:0] ang_diff;
  logic signed [32:0] ang_up;
  logic signed [32:0] ang_lo;
  logic signed [31:0] cs_t;
  logic signed [31:0] sn_t;
  logic signed [31:0] s1_t;
  logic signed [31:0] s2_t;

  assign ang_up   = $signed({in_tdata[31], in_tdata[31:0]});
  assign ang_lo   = $signed({in_tdata[63], in_tdata[63:32]});
  assign ang_diff = ang_up - ang_lo;

  dpd_sincos #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_diff (
    .clk(clk), .en(en), .angle(ang_diff), .cos_q30(cs_t), .sin_q30(sn_t)
  );
  dpd_sincos #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_up (
    .clk(clk), .en(en), .angle(ang_up), .cos_q30(), .sin_q30(s1_t)
  );
  dpd_sincos #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_lo (
    .clk(clk), .en(en), .angle(ang_lo), .cos_q30(), .sin_q30(s2_t)
  );

  // momenta wait alongside the trig units
  logic [63:0] p_dl_r [LT];
  always_ff @(posedge clk) begin
    if (en) begin
      p_dl_r[0] <= in_tdata[127:64];
      for (int i = 1; i < LT; i++) begin
        p_dl_r[i] <= p_dl_r[i-1];
      end
    end
  end

  logic signed [31:0] p1_t;
  logic signed [31:0] p2_t;
  logic signed [31:0] grav_s;
  assign p1_t   = $signed(p_dl_r[LT-1][31:0]);
  assign p2_t   = $signed(p_dl_r[LT-1][63:32]);
  assign grav_s = $signed({1'b0, gravity_r});

  // stage 1: squares, momentum products, gravity terms
  logic signed [63:0] cs_sq, pp_full, qq_full, pc1_full, pc2_full, g1_full, g2_full;
  logic [30:0]         cc1_r;
  logic signed [WPP-1:0] pp1_r, qq1_r;
  logic signed [63:0]  pc11_r, pc21_r;
  logic signed [31:0]  p11_r, p21_r, cs1_r, sn1_r;
  logic signed [33:0]  gt1_r, gt2_r;

  always_comb begin
    cs_sq    = cs_t * cs_t;
    pp_full  = p1_t * p2_t;
    qq_full  = p2_t * p2_t;
    pc1_full = p1_t * cs_t;
    pc2_full = p2_t * cs_t;
    g1_full  = grav_s * s1_t;
    g2_full  = grav_s * s2_t;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc1_r  <= cs_sq[60:30];
      pp1_r  <= WPP'(pp_full >>> FRAC_BITS);
      qq1_r  <= WPP'(qq_full >>> FRAC_BITS);
      pc11_r <= pc1_full;
      pc21_r <= pc2_full;
      p11_r  <= p1_t;
      p21_r  <= p2_t;
      cs1_r  <= cs_t;
      sn1_r  <= sn_t;
      gt1_r  <= 34'(g1_full >>> 29);
      gt2_r  <= 34'(g2_full >>> 30);
    end
  end

  // stage 2: denominator, coupling sums, angle-rate numerators
  logic [31:0]          den2_r;
  logic signed [32:0]   kk2_r;
  logic signed [WS-1:0] sum2_r;
  logic signed [WPP-1:0] pp2_r;
  logic signed [63:0]   n12_r, n22_r;
  logic signed [31:0]   cs2_r, sn2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      den2_r <= 32'h8000_0000 - {1'b0, cc1_r};
      kk2_r  <= 33'sd2147483648 + $signed({2'b00, cc1_r});
      sum2_r <= WS'(pp1_r) + (WS'(qq1_r) <<< 1);
      pp2_r  <= pp1_r;
      n12_r  <= pc21_r - (64'(p11_r) <<< 30);
      n22_r  <= pc11_r - (64'(p21_r) <<< 31);
      cs2_r  <= cs1_r;
      sn2_r  <= sn1_r;
    end
  end

  // angle rates: two dividers sharing the denominator
  logic signed [WQD:0] dq1_q, dq2_q;

  dpd_div #(.WN(64), .WD(32), .WQ(WQD)) u_div_dq1 (
    .clk(clk), .en(en), .dividend(n12_r), .divisor(den2_r), .quotient(dq1_q)
  );
  dpd_div #(.WN(64), .WD(32), .WQ(WQD)) u_div_dq2 (
    .clk(clk), .en(en), .dividend(n22_r), .divisor(den2_r), .quotient(dq2_q)
  );

  // stage 3: D*D and partial products of the two coupling terms
  logic [63:0]             den_sq;
  logic signed [WS-27:0]   sum_hi;
  logic signed [WPP-27:0]  pp_hi;
  logic [32:0]             dd3_r;
  logic signed [59:0]      t1l_r, t2l_r;
  logic signed [WS+5:0]    t1h_r;
  logic signed [WPP+6:0]   t2h_r;
  logic signed [31:0]      sn3_r;

  assign den_sq = den2_r * den2_r;
  assign sum_hi = sum2_r[WS-1:26];
  assign pp_hi  = pp2_r[WPP-1:26];

  always_ff @(posedge clk) begin
    if (en) begin
      dd3_r <= den_sq[62:30];
      t1l_r <= $signed({1'b0, sum2_r[25:0]}) * cs2_r;
      t1h_r <= sum_hi * cs2_r;
      t2l_r <= $signed({1'b0, pp2_r[25:0]}) * kk2_r;
      t2h_r <= pp_hi * kk2_r;
      sn3_r <= sn2_r;
    end
  end

  // stage 4: assemble and floor the coupling terms
  logic signed [WS+31:0]  full1;
  logic signed [WPP+32:0] full2;
  logic signed [WS-1:0]   t1_4_r, t2_4_r;
  logic [32:0]            dd4_r;
  logic signed [31:0]     sn4_r;

  assign full1 = ((WS+32)'(t1h_r) <<< 26) + (WS+32)'(t1l_r);
  assign full2 = ((WPP+33)'(t2h_r) <<< 26) + (WPP+33)'(t2l_r);

  always_ff @(posedge clk) begin
    if (en) begin
      t1_4_r <= WS'(full1 >>> 30);
      t2_4_r <= WS'(full2 >>> 30);
      dd4_r  <= dd3_r;
      sn4_r  <= sn3_r;
    end
  end

  // stage 5: inner difference
  logic signed [WI-1:0] inner5_r;
  logic [32:0]          dd5_r;
  logic signed [31:0]   sn5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      inner5_r <= WI'(t1_4_r) - WI'(t2_4_r);
      dd5_r    <= dd4_r;
      sn5_r    <= sn4_r;
    end
  end

  // stage 6: partial products of inner * sin(q1-q2)
  logic signed [WI-27:0] inner_hi;
  logic signed [59:0]    t3l_r;
  logic signed [WI+5:0]  t3h_r;
  logic [32:0]           dd6_r;

  assign inner_hi = inner5_r[WI-1:26];

  always_ff @(posedge clk) begin
    if (en) begin
      t3l_r <= $signed({1'b0, inner5_r[25:0]}) * sn5_r;
      t3h_r <= inner_hi * sn5_r;
      dd6_r <= dd5_r;
    end
  end

  // stage 7: numerator of f2
  logic signed [WI+31:0] full3;
  logic signed [WNU-1:0] numer7_r;
  logic [32:0]           dd7_r;
  logic signed [WNU+29:0] f2_dividend;

  assign full3       = ((WI+32)'(t3h_r) <<< 26) + (WI+32)'(t3l_r);
  assign f2_dividend = {numer7_r, 30'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      numer7_r <= WNU'(full3 >>> 30);
      dd7_r    <= dd6_r;
    end
  end

  // f2 = trunc(numer * 2^30 / D^2)
  logic signed [WQF:0] f2_q;

  dpd_div #(.WN(WNU + 30), .WD(33), .WQ(WQF)) u_div_f2 (
    .clk(clk), .en(en), .dividend(f2_dividend), .divisor(dd7_r), .quotient(f2_q)
  );

  // align angle rates and gravity terms with f2
  logic [2*WQD+1:0] dq_dl_r [DDQ];
  logic [67:0]      gt_dl_r [DG];

  always_ff @(posedge clk) begin
    if (en) begin
      dq_dl_r[0] <= {dq2_q, dq1_q};
      for (int i = 1; i < DDQ; i++) begin
        dq_dl_r[i] <= dq_dl_r[i-1];
      end
      gt_dl_r[0] <= {gt2_r, gt1_r};
      for (int i = 1; i < DG; i++) begin
        gt_dl_r[i] <= gt_dl_r[i-1];
      end
    end
  end

  // final stage: momentum rates, saturation, overflow
  logic signed [WSAT-1:0] v_dq1, v_dq2, v_dp1, v_dp2;
  logic [3:0]             sat_hit;
  logic [127:0]           res_nxt;
  logic [127:0]           out_tdata_r;
  logic                   ovf_r;

  function automatic logic [31:0] clip32(input logic signed [WSAT-1:0] v);
    logic [31:0] r;
    if (v > SMAX) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SMIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    v_dq1 = WSAT'($signed(dq_dl_r[DDQ-1][WQD:0]));
    v_dq2 = WSAT'($signed(dq_dl_r[DDQ-1][2*WQD+1:WQD+1]));
    v_dp1 = WSAT'($signed(gt_dl_r[DG-1][33:0])) - WSAT'(f2_q);
    v_dp2 = WSAT'(f2_q) + WSAT'($signed(gt_dl_r[DG-1][67:34]));
    sat_hit[0] = (v_dq1 > SMAX) || (v_dq1 < SMIN);
    sat_hit[1] = (v_dq2 > SMAX) || (v_dq2 < SMIN);
    sat_hit[2] = (v_dp1 > SMAX) || (v_dp1 < SMIN);
    sat_hit[3] = (v_dp2 > SMAX) || (v_dp2 < SMIN);
    res_nxt = {clip32(v_dp2), clip32(v_dp1), clip32(v_dq2), clip32(v_dq1)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= res_nxt;
      ovf_r       <= |sat_hit;
    end
  end

  assign out_tvalid   = vld_r[LAT-1];
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = ovf_r;

  // cos of the difference angle and sin of the upper angle stay within [-1, 1]
  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LT-1] |-> (cs_t <= 32'sd1073741824) && (cs_t >= -32'sd1073741824) &&
                    (s1_t <= 32'sd1073741824) && (s1_t >= -32'sd1073741824))
    else $error("trig output out of range");

  // D in [1, 2]
  a_den_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LT+1] |-> (den2_r >= 32'h4000_0000) && (den2_r <= 32'h8000_0000))
    else $error("denominator out of range");

  // D*D in [1, 4], never a zero divisor
  a_dd_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LT+6] |-> (dd7_r >= 33'h0_4000_0000) && (dd7_r <= 33'h1_0000_0000))
    else $error("squared denominator out of range");

  // overflow flag comes with a clipped rate
  a_ovf_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[31:0] == 32'h7FFF_FFFF) || (out_tdata[31:0] == 32'h8000_0000) ||
      (out_tdata[63:32] == 32'h7FFF_FFFF) || (out_tdata[63:32] == 32'h8000_0000) ||
      (out_tdata[95:64] == 32'h7FFF_FFFF) || (out_tdata[95:64] == 32'h8000_0000) ||
      (out_tdata[127:96] == 32'h7FFF_FFFF) || (out_tdata[127:96] == 32'h8000_0000))
    else $error("overflow without clipped rate");

  // a stall freezes the valid pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> vld_r == $past(vld_r))
    else $error("valid pipeline moved during stall");

endmodule
